FILE: design/i2c_master_byte_engine_defines.svh
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_RD_ACK  = 3'd4;
    localparam logic [2:0] OP_RD_NACK = 3'd5;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd4;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } t_out_item;

endpackage

`default_nettype wire

FILE: design/i2cm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  i2cm_pkg::t_in_item  i_item,
    input  wire  [7:0]          i_phase_ticks,
    output i2cm_pkg::t_out_item o_result
);

    localparam logic [4:0] LEN_SHORT = 5'd4;
    localparam logic [4:0] LEN_WRITE = 5'd19;
    localparam logic [4:0] LEN_RD_ACK = 5'd20;
    localparam logic [4:0] LEN_RD_NACK = 5'd19;
    localparam logic [4:0] DATA_STEPS = 5'd16;

    logic [7:0] r_pc, n_pc;
    logic [4:0] r_step, n_step;
    logic [7:0] r_sr, n_sr;
    logic [2:0] r_op, n_op;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_busy, n_busy;

    logic       w_start;
    logic       w_busy;
    logic [2:0] w_op;
    logic [4:0] w_step;
    logic [4:0] w_step1;
    logic [7:0] w_pc1;
    logic [7:0] w_sr;
    logic [7:0] w_limit;
    logic [4:0] w_len;
    logic [1:0] w_lv;

    function automatic logic [4:0] seq_len(input logic [2:0] op);
        logic [4:0] len;
        unique case (op)
            i2cm_pkg::OP_START, i2cm_pkg::OP_RESTART, i2cm_pkg::OP_STOP: len = LEN_SHORT;
            i2cm_pkg::OP_WRITE:   len = LEN_WRITE;
            i2cm_pkg::OP_RD_ACK:  len = LEN_RD_ACK;
            default:              len = LEN_RD_NACK;
        endcase
        return len;
    endfunction

    // {scl, sda} for one phase of a sequence
    function automatic logic [1:0] phase_levels(
        input logic [2:0] op,
        input logic [4:0] p,
        input logic       msb,
        input logic       scl_keep,
        input logic       sda_keep
    );
        logic s_c;
        logic s_d;
        s_c = 1'b0;
        s_d = 1'b1;
        unique case (op)
            i2cm_pkg::OP_START: begin
                s_c = (p == 5'd0) ? scl_keep : (p <= 5'd2);
                s_d = (p <= 5'd1);
            end
            i2cm_pkg::OP_RESTART: begin
                s_c = (p >= 5'd2);
                s_d = (p == 5'd0) ? sda_keep : (p != 5'd3);
            end
            i2cm_pkg::OP_STOP: begin
                s_c = (p >= 5'd2);
                s_d = (p == 5'd0) ? sda_keep : (p == 5'd3);
            end
            default: begin
                if (p < DATA_STEPS) begin
                    s_c = p[0];
                    s_d = (op == i2cm_pkg::OP_WRITE) ? msb : 1'b1;
                end else begin
                    s_c = (p[1:0] == 2'd1);
                    if (op == i2cm_pkg::OP_WRITE) begin
                        s_d = 1'b0;
                    end else if (op == i2cm_pkg::OP_RD_ACK) begin
                        s_d = (p[1:0] == 2'd3);
                    end else begin
                        s_d = 1'b1;
                    end
                end
            end
        endcase
        return {s_c, s_d};
    endfunction

    always_comb begin
        w_start = !r_busy && i_item.cmd_valid && (i_item.op <= i2cm_pkg::OP_RD_NACK);
        w_busy  = r_busy || w_start;
        w_op    = w_start ? i_item.op : r_op;
        w_step  = w_start ? 5'd0 : r_step;
        w_pc1   = (w_start ? 8'd0 : r_pc) + 8'd1;
        w_sr    = r_sr;
        if (w_start) begin
            w_sr = (i_item.op == i2cm_pkg::OP_WRITE) ? i_item.tx_byte : 8'd0;
        end
        w_limit = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
        w_step1 = w_step + 5'd1;
        w_len   = seq_len(w_op);
        w_lv    = phase_levels(w_op, w_step, w_sr[7], r_scl, r_sda);

        n_pc   = r_pc;
        n_step = r_step;
        n_sr   = r_sr;
        n_op   = r_op;
        n_scl  = r_scl;
        n_sda  = r_sda;
        n_busy = r_busy;

        o_result          = '0;
        o_result.scl      = r_scl;
        o_result.sda_out  = r_sda;

        if (w_busy) begin
            o_result.busy_res = 1'b1;
            o_result.scl      = w_lv[1];
            o_result.sda_out  = w_lv[0];
            n_scl  = w_lv[1];
            n_sda  = w_lv[0];
            n_op   = w_op;
            n_busy = 1'b1;
            n_step = w_step;
            n_sr   = w_sr;
            n_pc   = w_pc1;
            if (w_pc1 >= w_limit) begin
                n_pc = 8'd0;
                if (w_op >= i2cm_pkg::OP_WRITE && w_step < DATA_STEPS && w_step[0]) begin
                    n_sr = (w_op == i2cm_pkg::OP_WRITE) ? {w_sr[6:0], 1'b0}
                                                        : {w_sr[6:0], i_item.sda_in};
                end
                n_step = w_step1;
                if (w_step1 >= w_len) begin
                    o_result.done_res = 1'b1;
                    n_busy = 1'b0;
                    n_step = 5'd0;
                    if (w_op >= i2cm_pkg::OP_RD_ACK) begin
                        o_result.rx_byte = n_sr;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 8'd0;
            r_step <= 5'd0;
            r_sr   <= 8'd0;
            r_op   <= 3'd0;
            r_scl  <= 1'b1;
            r_sda  <= 1'b1;
            r_busy <= 1'b0;
        end else if (i_step) begin
            r_pc   <= n_pc;
            r_step <= n_step;
            r_sr   <= n_sr;
            r_op   <= n_op;
            r_scl  <= n_scl;
            r_sda  <= n_sda;
            r_busy <= n_busy;
        end
    end

endmodule

`default_nettype wire

FILE: design/i2c_master_byte_engine.sv
// I2C master line sequencer. Every input item is one bus tick and yields exactly one
// output item with the SCL/SDA levels to drive, busy, done and the received byte. A
// command (start, repeated start, stop, byte write, byte read with ACK or NOACK) is
// taken only when the sequencer is idle; each line phase lasts phase_ticks ticks
// (zero acts as one). One item is accepted per clock while o_in_stall is low; an item
// goes through an input register and then a result register before its result is
// offered, and a stalled result holds the input stall high in the same cycle while
// an item waits in the input register. phase_ticks resets to 4; the user writes it through
// i_cfg_we / i_cfg_wdata only while the block is idle, not enforced by the block.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [7:0]          i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  i2cm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output i2cm_pkg::t_out_item o_out_item
);

    logic                r_in_vld;
    i2cm_pkg::t_in_item  r_in_item;
    logic                r_out_vld;
    i2cm_pkg::t_out_item r_out_item;
    logic [7:0]          r_phase_ticks;
    logic                w_adv;
    i2cm_pkg::t_out_item w_result;

    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    i2cm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_item        (r_in_item),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= w_result;
        end
    end

endmodule

`default_nettype wire

FILE: design/i2cm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"

module i2cm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input i2cm_pkg::t_out_item o_out_item
);

    logic w_done;
    logic w_rx_nz;

    assign w_done  = o_out_valid && o_out_item.done_res;
    assign w_rx_nz = o_out_valid && (o_out_item.rx_byte != 8'd0);

    `I2CM_ASSERT_NOW(a_done_in_seq, w_done, o_out_item.busy_res, "done outside a sequence")
    `I2CM_ASSERT_NOW(a_rx_only_on_done, w_rx_nz, o_out_item.done_res, "rx byte without done")
    `I2CM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled item changed")
    `I2CM_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled with free output")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
